FILE: rtl/length_field_deframer_top_assert.svh
// Assertion macros used by the length field deframer top level.
`ifndef LENGTH_FIELD_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_FIELD_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Deframer assertion failed.");

// Next-cycle implication, checked at every rising edge outside reset.
`define LFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Deframer assertion failed.");

`endif

FILE: rtl/lfd_pkg.sv
// Types and constants shared by the length field deframer modules.
package lfd_pkg;

  localparam logic [1:0] ST_HEADER = 2'd0;
  localparam logic [1:0] ST_BODY   = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  localparam logic [1:0] REG_FIELD_OFFSET = 2'd0;
  localparam logic [1:0] REG_FIELD_BYTES  = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;
  localparam logic [1:0] REG_BIG_ENDIAN   = 2'd3;

  localparam logic [7:0] RST_FIELD_OFFSET = 8'd0;
  localparam logic [3:0] RST_FIELD_BYTES  = 4'd4;
  localparam logic [7:0] RST_HEADER_BYTES = 8'd4;
  localparam logic       RST_BIG_ENDIAN   = 1'b1;

  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  typedef struct packed {
    logic [7:0] field_offset;
    logic [3:0] field_bytes;
    logic [7:0] header_bytes;
    logic       big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] frame_length;
  } result_t;

endpackage

FILE: rtl/lfd_apb_regs.sv
// APB configuration register file of the length field deframer.
module lfd_apb_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lfd_pkg::cfg_t cfg
);

  lfd_pkg::cfg_t cfg_r;
  lfd_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        lfd_pkg::REG_FIELD_OFFSET: cfg_nxt.field_offset = pwdata[7:0];
        lfd_pkg::REG_FIELD_BYTES:  cfg_nxt.field_bytes  = pwdata[3:0];
        lfd_pkg::REG_HEADER_BYTES: cfg_nxt.header_bytes = pwdata[7:0];
        lfd_pkg::REG_BIG_ENDIAN:   cfg_nxt.big_endian   = pwdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_offset <= lfd_pkg::RST_FIELD_OFFSET;
      cfg_r.field_bytes  <= lfd_pkg::RST_FIELD_BYTES;
      cfg_r.header_bytes <= lfd_pkg::RST_HEADER_BYTES;
      cfg_r.big_endian   <= lfd_pkg::RST_BIG_ENDIAN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lfd_pkg::REG_FIELD_OFFSET: prdata = {24'd0, cfg_r.field_offset};
      lfd_pkg::REG_FIELD_BYTES:  prdata = {28'd0, cfg_r.field_bytes};
      lfd_pkg::REG_HEADER_BYTES: prdata = {24'd0, cfg_r.header_bytes};
      lfd_pkg::REG_BIG_ENDIAN:   prdata = {31'd0, cfg_r.big_endian};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/lfd_step.sv
// Frame state registers and the per-byte update of the length field deframer.
module lfd_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [7:0]       data_byte,
  input  logic             clear,
  input  lfd_pkg::cfg_t    cfg,
  output lfd_pkg::result_t res
);

  logic [63:0] pos_r;
  logic [63:0] pos_nxt;
  logic [63:0] len_r;
  logic [63:0] len_nxt;
  logic        err_r;
  logic        err_nxt;

  logic [63:0] p;
  logic [63:0] np;
  logic [63:0] lv;
  logic [63:0] lv_new;
  logic [63:0] total;
  logic [7:0]  hb;
  logic [3:0]  fb;
  logic [7:0]  k;
  logic        err;
  logic        in_field;
  logic        over;

  always_comb begin
    p   = clear ? 64'd0 : pos_r;
    lv  = clear ? 64'd0 : len_r;
    err = clear ? 1'b0 : err_r;
    hb  = (cfg.header_bytes == 8'd0) ? 8'd1 : cfg.header_bytes;
    fb  = (cfg.field_bytes > lfd_pkg::MAX_FIELD_BYTES) ? lfd_pkg::MAX_FIELD_BYTES
                                                       : cfg.field_bytes;
    k   = p[7:0] - cfg.field_offset;
    in_field = (p < {56'd0, hb}) && (p[7:0] >= cfg.field_offset) && ({4'd0, fb} > k);

    lv_new = lv;
    if (in_field) begin
      if (cfg.big_endian) begin
        lv_new = {lv[55:0], data_byte};
      end else begin
        lv_new = lv | ({56'd0, data_byte} << {k[2:0], 3'b000});
      end
    end

    np    = p + 64'd1;
    over  = lv_new[63] || (&lv_new[62:0]);
    total = {56'd0, hb} + lv_new;

    pos_nxt          = pos_r;
    len_nxt          = len_r;
    err_nxt          = err;
    res.status       = lfd_pkg::ST_HEADER;
    res.frame_length = 64'd0;

    if (err) begin
      res.status = lfd_pkg::ST_ERROR;
    end else if (np < {56'd0, hb}) begin
      pos_nxt = np;
      len_nxt = lv_new;
    end else if (over) begin
      res.status = lfd_pkg::ST_ERROR;
      err_nxt    = 1'b1;
      pos_nxt    = 64'd0;
      len_nxt    = 64'd0;
    end else begin
      res.frame_length = total;
      if (np >= total) begin
        res.status = lfd_pkg::ST_DONE;
        pos_nxt    = 64'd0;
        len_nxt    = 64'd0;
      end else begin
        res.status = lfd_pkg::ST_BODY;
        pos_nxt    = np;
        len_nxt    = lv_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 64'd0;
      len_r <= 64'd0;
      err_r <= 1'b0;
    end else if (adv) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

FILE: rtl/length_field_deframer_top.sv
// Top level of the length field deframer: input register, step logic, result register.
//
//   channel  direction  handshake            payload
//   in       in         in_valid, in_stall   in_data_byte, in_clear
//   out      out        out_valid, out_stall out_status, out_frame_length
//   cfg      in         psel, penable        paddr, pwdata, prdata
//
// Each byte is held in the input register and then passes to the result register; one
// transaction is taken every cycle while the result register is not stalled.
// The frame position and length registers are updated when a byte moves to the result
// register. Reset is synchronous and restores the register defaults and an empty frame.
// A stalled result holds the input register, and in_stall rises only when it is full.
module length_field_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_frame_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lfd_pkg::cfg_t    cfg;
  lfd_pkg::result_t res;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_clear_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [63:0] out_len_r;
  logic        out_free;
  logic        adv;
  logic        in_acc;

  lfd_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (s1_byte_r),
    .clear     (s1_clear_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_data_byte;
      s1_clear_r <= in_clear;
    end
    if (adv) begin
      out_status_r <= res.status;
      out_len_r    <= res.frame_length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_length = out_len_r;

`include "length_field_deframer_top_assert.svh"

  `LFD_ASSERT_IMPL(a_err_len_zero, out_valid && (out_status == lfd_pkg::ST_ERROR), out_frame_length == 64'd0)
  `LFD_ASSERT_IMPL(a_hdr_len_zero, out_valid && (out_status == lfd_pkg::ST_HEADER), out_frame_length == 64'd0)
  `LFD_ASSERT_IMPL(a_body_len_set, out_valid && (out_status == lfd_pkg::ST_BODY || out_status == lfd_pkg::ST_DONE), out_frame_length != 64'd0)
  `LFD_ASSERT_NEXT(a_s1_held, s1_valid_r && !adv, s1_valid_r)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the length field deframer: framed byte streams, gaps and stalls.
module tb_top;

  localparam logic [63:0] LENGTH_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_clear = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_frame_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  lfd_pkg::cfg_t    regs;
  logic [63:0]      frame_pos;
  logic [63:0]      field_value;
  logic             err_held;
  lfd_pkg::result_t expected_results[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned errors_seen = 0;
  int unsigned mismatches = 0;
  bit          realign_pending = 1'b0;

  length_field_deframer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_clear(in_clear),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_frame_length(out_frame_length),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic lfd_pkg::result_t deframe_byte(logic [7:0] data, logic clr);
    logic [63:0] hdr, fld, pos, nxt, total;
    lfd_pkg::result_t r;
    hdr = (regs.header_bytes == 8'd0) ? 64'd1 : 64'(regs.header_bytes);
    fld = (regs.field_bytes > lfd_pkg::MAX_FIELD_BYTES) ? 64'(lfd_pkg::MAX_FIELD_BYTES)
                                                        : 64'(regs.field_bytes);
    if (clr) begin
      frame_pos = 64'd0;
      field_value = 64'd0;
      err_held = 1'b0;
    end
    r.status = lfd_pkg::ST_ERROR;
    r.frame_length = 64'd0;
    if (err_held) return r;
    pos = frame_pos;
    if (pos < hdr && pos >= 64'(regs.field_offset) && pos - 64'(regs.field_offset) < fld) begin
      if (regs.big_endian) begin
        field_value = {field_value[55:0], data};
      end else begin
        field_value = field_value | (64'(data) << (8 * (pos - 64'(regs.field_offset))));
      end
    end
    nxt = pos + 64'd1;
    if (nxt < hdr) begin
      frame_pos = nxt;
      r.status = lfd_pkg::ST_HEADER;
      return r;
    end
    if (field_value >= LENGTH_LIMIT) begin
      err_held = 1'b1;
      frame_pos = 64'd0;
      field_value = 64'd0;
      return r;
    end
    total = hdr + field_value;
    r.frame_length = total;
    if (nxt >= total) begin
      r.status = lfd_pkg::ST_DONE;
      frame_pos = 64'd0;
      field_value = 64'd0;
    end else begin
      r.status = lfd_pkg::ST_BODY;
      frame_pos = nxt;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    lfd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("Unexpected transaction: status %0d, frame_length %0d",
                                out_status, out_frame_length));
      end else begin
        want = expected_results.pop_front();
        if (out_status != want.status) begin
          flag_mismatch($sformatf("Result %0d status: expected %0d, got %0d",
                                  results_seen, want.status, out_status));
        end
        if (out_frame_length != want.frame_length) begin
          flag_mismatch($sformatf("Result %0d frame_length: expected %0d, got %0d",
                                  results_seen, want.frame_length, out_frame_length));
        end
        if (want.status == lfd_pkg::ST_DONE) frames_done++;
        if (want.status == lfd_pkg::ST_ERROR) errors_seen++;
      end
    end
  end

  task automatic send_byte(logic [7:0] data, logic clr);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_clear <= clr;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(deframe_byte(data, clr));
    bytes_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lfd_pkg::REG_FIELD_OFFSET: regs.field_offset = val[7:0];
      lfd_pkg::REG_FIELD_BYTES:  regs.field_bytes = val[3:0];
      lfd_pkg::REG_HEADER_BYTES: regs.header_bytes = val[7:0];
      lfd_pkg::REG_BIG_ENDIAN:   regs.big_endian = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(lfd_pkg::cfg_t c);
    write_reg(lfd_pkg::REG_FIELD_OFFSET, 32'(c.field_offset));
    write_reg(lfd_pkg::REG_FIELD_BYTES, 32'(c.field_bytes));
    write_reg(lfd_pkg::REG_HEADER_BYTES, 32'(c.header_bytes));
    write_reg(lfd_pkg::REG_BIG_ENDIAN, 32'(c.big_endian));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic lfd_pkg::cfg_t pick_config();
    lfd_pkg::cfg_t c;
    int unsigned off, fb;
    c.big_endian = 1'($urandom_range(1));
    case ($urandom_range(11))
      0: begin
        c.field_offset = 8'd0;
        c.field_bytes = 4'd1;
        c.header_bytes = 8'd1;
      end
      1: begin
        // The field runs past the end of the largest header.
        c.field_offset = 8'd254;
        c.field_bytes = lfd_pkg::MAX_FIELD_BYTES;
        c.header_bytes = 8'd255;
      end
      2: begin
        c.field_offset = 8'd0;
        c.field_bytes = 4'd0;
        c.header_bytes = 8'd2;
      end
      3: begin
        c.field_offset = 8'd1;
        c.field_bytes = 4'd15;
        c.header_bytes = 8'd9;
      end
      4: begin
        c.field_offset = 8'd0;
        c.field_bytes = 4'd2;
        c.header_bytes = 8'd0;
      end
      5: begin
        c.field_offset = 8'd5;
        c.field_bytes = 4'd3;
        c.header_bytes = 8'd7;
      end
      default: begin
        fb = $urandom_range(1, 8);
        off = $urandom_range(6);
        c.field_offset = 8'(off);
        c.field_bytes = 4'(fb);
        c.header_bytes = 8'(off + fb + $urandom_range(4));
      end
    endcase
    return c;
  endfunction

  task automatic send_frame();
    logic [63:0] body_len;
    logic [7:0]  data;
    logic        clr;
    int          hdr, fld, off, to_send;
    hdr = (regs.header_bytes == 8'd0) ? 1 : int'(regs.header_bytes);
    fld = (regs.field_bytes > lfd_pkg::MAX_FIELD_BYTES) ? int'(lfd_pkg::MAX_FIELD_BYTES)
                                                        : int'(regs.field_bytes);
    off = int'(regs.field_offset);
    case ($urandom_range(19))
      0, 1, 2: body_len = 64'($urandom_range(300));
      3: begin
        case ($urandom_range(3))
          0: body_len = LENGTH_LIMIT - 64'd1;
          1: body_len = LENGTH_LIMIT;
          2: body_len = {1'b1, 31'($urandom), 32'($urandom)};
          default: body_len = '1;
        endcase
      end
      4: body_len = {32'($urandom), 32'($urandom)};
      default: body_len = 64'($urandom_range(12));
    endcase
    if (fld < 8) body_len = body_len & ((64'd1 << (8 * fld)) - 64'd1);
    if (body_len > 64'd300 || off + fld > hdr) begin
      to_send = $urandom_range(6);
    end else begin
      to_send = int'(body_len);
    end
    for (int i = 0; i < hdr; i++) begin
      if (i >= off && i - off < fld) begin
        data = 8'(body_len >> (8 * (regs.big_endian ? fld - 1 - (i - off) : i - off)));
      end else begin
        data = 8'($urandom);
      end
      if (i == 0) begin
        clr = realign_pending || ($urandom_range(19) == 0);
        realign_pending = 1'b0;
      end else begin
        clr = ($urandom_range(199) == 0);
        if (clr) realign_pending = 1'b1;
      end
      send_byte(data, clr);
    end
    for (int j = 0; j < to_send; j++) begin
      clr = ($urandom_range(199) == 0);
      if (clr) realign_pending = 1'b1;
      send_byte(8'($urandom), clr);
    end
    if (to_send != int'(body_len) || body_len > 64'd300) realign_pending = 1'b1;
  endtask

  task automatic run_settings(int unsigned n_settings, int unsigned bytes_each);
    int unsigned stop_at;
    repeat (n_settings) begin
      drain_results();
      apply_config(pick_config());
      if ($urandom_range(1) == 0) realign_pending = 1'b1;
      stop_at = bytes_sent + bytes_each;
      while (bytes_sent < stop_at) begin
        send_frame();
        if ($urandom_range(49) == 0) drain_results();
      end
    end
  endtask

  task automatic test_directed_frames();
    lfd_pkg::cfg_t c;
    gap_pct = 0;
    stall_pct = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    drain_results();
    c.field_offset = 8'd0;
    c.field_bytes = lfd_pkg::MAX_FIELD_BYTES;
    c.header_bytes = 8'd8;
    c.big_endian = 1'b1;
    apply_config(c);
    send_byte(8'h7F, 1'b0);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAA, 1'b0);
  endtask

  task automatic test_back_to_back();
    gap_pct = 0;
    stall_pct = 0;
    run_settings(4, 50);
  endtask

  task automatic test_sender_gaps();
    gap_pct = 55;
    stall_pct = 0;
    run_settings(4, 50);
  endtask

  task automatic test_receiver_stalls();
    gap_pct = 0;
    stall_pct = 55;
    run_settings(4, 50);
  endtask

  task automatic test_mixed_gaps();
    gap_pct = 28;
    stall_pct = 28;
    run_settings(4, 50);
  endtask

  initial begin
    regs.field_offset = lfd_pkg::RST_FIELD_OFFSET;
    regs.field_bytes = lfd_pkg::RST_FIELD_BYTES;
    regs.header_bytes = lfd_pkg::RST_HEADER_BYTES;
    regs.big_endian = lfd_pkg::RST_BIG_ENDIAN;
    frame_pos = 64'd0;
    field_value = 64'd0;
    err_held = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    gap_pct = 0;
    stall_pct = 0;
    drain_results();
    $display("Sent %0d bytes over many header layouts, checked %0d results.",
             bytes_sent, results_seen);
    $display("Saw %0d completed frames and %0d error results; %0d mismatches.",
             frames_done, errors_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lfd_pkg.sv
rtl/lfd_apb_regs.sv
rtl/lfd_step.sv
rtl/length_field_deframer_top.sv
test/tb_top.sv
